// ===== hdl/sdsh_pkg.sv =====
// Package for the SD SPI host sequencer: field widths, phase, step and status codes.
// No dependencies.
package sdsh_pkg;
	localparam int BLOCK_BYTES = 512;
	localparam logic [5:0] PH_IDLE = 6'd0, PH_FILL = 6'd1, PH_CFLUSH = 6'd2, PH_CPRE = 6'd3,
		PH_CFRAME = 6'd4, PH_CPOLL = 6'd5, PH_TOKEN = 6'd6, PH_RDATA = 6'd7, PH_RCRC = 6'd8,
		PH_READY = 6'd9, PH_WAITWB = 6'd10, PH_WDATA = 6'd11, PH_WTOKEN = 6'd12,
		PH_WCRC = 6'd13, PH_WRESP = 6'd14, PH_STOP = 6'd15;
	localparam logic [4:0] S_NONE = 5'd0, S_I_FLUSH = 5'd1, S_I_CMD0 = 5'd2, S_I_CMD8 = 5'd3,
		S_I_R7 = 5'd4, S_I_C55 = 5'd5, S_I_C41 = 5'd6, S_I_C1 = 5'd7, S_OCR_C1 = 5'd8,
		S_OCR_R1 = 5'd9, S_OCR_C2 = 5'd10, S_OCR_R2 = 5'd11, S_I_C59 = 5'd12,
		S_I_C16 = 5'd13, S_REG_C = 5'd14, S_REG_R = 5'd15, S_R_C = 5'd16, S_R_D = 5'd17,
		S_R_STOP = 5'd18, S_R_FILL = 5'd19, S_W_55 = 5'd20, S_W_23 = 5'd21, S_W_C = 5'd22,
		S_W_RDY = 5'd23, S_W_END = 5'd24, S_SYNC = 5'd25;
	localparam logic [1:0] RT_START = 2'd0, RT_BYTE = 2'd1, RT_TICK = 2'd2, RT_WBYTE = 2'd3;
	localparam logic [2:0] OP_INIT = 3'd0, OP_READ = 3'd1, OP_WRITE = 3'd2, OP_SYNC = 3'd3,
		OP_CSD = 3'd4, OP_CID = 3'd5, OP_OCR = 3'd6;
	localparam logic [1:0] ST_OK = 2'd0, ST_ERR = 2'd1, ST_NRDY = 2'd2, ST_WP = 2'd3;
	localparam logic [1:0] CFG_TRIES = 2'd0, CFG_TIMEOUT = 2'd1, CFG_WP = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] op;
		logic [31:0] sector;
		logic [15:0] block_count;
		logic [7:0] miso_byte;
		logic [7:0] write_byte;
	} item_t;

	typedef struct packed {
		logic tx_valid;
		logic [7:0] tx_byte;
		logic cs_low;
		logic read_valid;
		logic [7:0] read_data;
		logic need_write_byte;
		logic done_res;
		logic [1:0] status;
		logic [1:0] card_kind;
		logic high_capacity;
		logic [31:0] sector_total;
		logic card_ready;
	} res_t;

	typedef struct packed {
		logic [7:0] tries;
		logic [15:0] timeout;
		logic wp;
	} cfg_t;
endpackage

// ===== hdl/sd_spi_host_sequencer.sv =====
// SD card SPI mode host sequencer, top level.
// Input register, sequencer step and result register; depends on sdsh_pkg,
// sdsh_cfg and sdsh_core.
//
// Usage: events arrive on the s_axis channel. tuser carries req_type; tdata
// carries op, sector, block_count, miso_byte and write_byte. Each event gives
// at most one result on m_axis: the next SPI byte with the chip-select level,
// a read byte, a write byte request or completion status, plus the card
// registers. The environment exchanges each emitted SPI byte and returns the
// received byte as an event.
// A result is computed from the input register by the sequencer step and is loaded
// into the result register. Throughput: one event per cycle while the receiver does
// not stall, set by the single-step sequencer between the two registers.
// Reset clears the sequencer to idle with chip select released and no card.
// When the receiver stalls, the result register holds and the input
// register takes at most one more event before s_axis_tready drops.
// cfg_we/cfg_index/cfg_data write response_tries, timeout_ms, write_protect.
module sd_spi_host_sequencer import sdsh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	input logic [71:0] s_axis_tdata, // op, sector, block_count, miso_byte, write_byte, pad
	input logic [1:0] s_axis_tuser, // req_type
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// tx_valid, tx_byte, cs_low, read_valid, read_data, need_write_byte, done_res,
	// status, card_kind, high_capacity, sector_total, card_ready, pad
	output logic [63:0] m_axis_tdata,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data
);
	cfg_t cfg;
	item_t item_s1;
	logic v_s1, v_s2, adv, emit;
	res_t res, res_s2;

	sdsh_cfg u_cfg (.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cfg);

	assign adv = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (s_axis_tready) v_s1 <= s_axis_tvalid;
	end
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid)
			item_s1 <= '{req_type: s_axis_tuser, op: s_axis_tdata[2:0],
				sector: s_axis_tdata[34:3], block_count: s_axis_tdata[50:35],
				miso_byte: s_axis_tdata[58:51], write_byte: s_axis_tdata[66:59]};
	end

	sdsh_core u_core (.clk, .arst_n, .cfg, .in_fire(v_s1 && adv), .item(item_s1),
		.res_emit(emit), .res);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1 && emit;
	end
	always_ff @(posedge clk) begin
		if (adv && v_s1 && emit) res_s2 <= res;
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata = {5'd0, res_s2.card_ready, res_s2.sector_total, res_s2.high_capacity,
		res_s2.card_kind, res_s2.status, res_s2.done_res, res_s2.need_write_byte,
		res_s2.read_data, res_s2.read_valid, res_s2.cs_low, res_s2.tx_byte, res_s2.tx_valid};
endmodule

// ===== hdl/sdsh_cfg.sv =====
// Configuration registers of the SD SPI host sequencer.
// Depends on sdsh_pkg.
module sdsh_cfg import sdsh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	output cfg_t cfg
);
	cfg_t cfg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{tries: 8'd10, timeout: 16'd255, wp: 1'b0};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TRIES: cfg_q.tries <= cfg_data[7:0];
				CFG_TIMEOUT: cfg_q.timeout <= cfg_data;
				CFG_WP: cfg_q.wp <= cfg_data[0];
				default: ;
			endcase
		end
	end
	assign cfg = cfg_q;
endmodule

// ===== hdl/sdsh_core.sv =====
// Sequencer state and one-step transition logic for each accepted event.
// Depends on sdsh_pkg.
module sdsh_core import sdsh_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cfg_t cfg,
	input logic in_fire,
	input item_t item,
	output logic res_emit,
	output res_t res
);
	logic [5:0] phase_q, phase_d;
	logic [4:0] seq_q, seq_d;
	logic [9:0] bidx_q, bidx_d;
	logic [15:0] blk_q, blk_d, tick_q, tick_d;
	logic [7:0] poll_q, poll_d;
	logic [47:0] frame_q, frame_d;
	logic [21:0] csd_q, csd_d;
	logic [1:0] kind_q, kind_d;
	logic dens_q, dens_d, rdy_q, rdy_d;
	logic [31:0] total_q, total_d, sec_q, sec_d;
	logic [2:0] op_q, op_d;
	logic cs_q, cs_d, emit_q, emit_d, multi_q, multi_d, hcs_q, hcs_d;
	logic r7_q, r7_d, ochc_q, ochc_d, oret_q, oret_d;
	logic [4:0] rlen_q, rlen_d;
	logic rlong_q, rlong_d;

	always_comb begin
		logic o_v, o_txv, o_nwb, o_dn, o_rv;
		logic [7:0] o_txb, o_rd, b;
		logic [1:0] o_st, fst;
		logic do_cont, fin, cmd, fill, resp, rdy, rwait, remit, ok;
		logic [7:0] cv, cidx, ccrc;
		logic [31:0] carg;
		logic [15:0] flen, rl, blk_m;
		logic [22:0] cp1;
		phase_d = phase_q; seq_d = seq_q; bidx_d = bidx_q; blk_d = blk_q; tick_d = tick_q;
		poll_d = poll_q; frame_d = frame_q; csd_d = csd_q; kind_d = kind_q; dens_d = dens_q;
		rdy_d = rdy_q; total_d = total_q; sec_d = sec_q; op_d = op_q; cs_d = cs_q;
		emit_d = emit_q; multi_d = multi_q; hcs_d = hcs_q; r7_d = r7_q; ochc_d = ochc_q;
		oret_d = oret_q; rlen_d = rlen_q; rlong_d = rlong_q;
		o_v = 1'b0; o_txv = 1'b0; o_txb = 8'd0; o_nwb = 1'b0; o_dn = 1'b0; o_st = ST_OK;
		o_rv = 1'b0; o_rd = 8'd0;
		do_cont = 1'b0; cv = 8'd0; fin = 1'b0; fst = ST_OK;
		cmd = 1'b0; cidx = 8'd0; carg = 32'd0; ccrc = 8'd0;
		fill = 1'b0; flen = 16'd0; resp = 1'b0; rl = 16'd0; rwait = 1'b0; remit = 1'b0;
		rdy = 1'b0; ok = 1'b0; cp1 = 23'd0; blk_m = blk_q - 16'd1;
		b = item.miso_byte;
		if (in_fire) begin
			case (item.req_type)
				RT_START: if (phase_q == PH_IDLE) begin
					op_d = item.op;
					case (item.op)
						OP_INIT: begin
							kind_d = 2'd0; dens_d = 1'b0; rdy_d = 1'b0; total_d = 32'd0;
							hcs_d = 1'b0; cs_d = 1'b0; seq_d = S_I_FLUSH;
							fill = 1'b1; flen = 16'd15;
						end
						OP_READ: begin
							if (!rdy_q) begin fin = 1'b1; fst = ST_NRDY; end
							else begin
								blk_d = item.block_count; multi_d = item.block_count != 16'd1;
								sec_d = item.sector; seq_d = S_R_C; cmd = 1'b1;
								cidx = (item.block_count != 16'd1) ? 8'd18 : 8'd17;
								carg = item.sector; ccrc = 8'hFF;
							end
						end
						OP_WRITE: begin
							if (!rdy_q) begin fin = 1'b1; fst = ST_NRDY; end
							else if (cfg.wp) begin fin = 1'b1; fst = ST_WP; end
							else begin
								blk_d = item.block_count; multi_d = item.block_count != 16'd1;
								sec_d = item.sector; cmd = 1'b1; ccrc = 8'hFF;
								if (item.block_count != 16'd1 && kind_q == 2'd3) begin
									seq_d = S_W_55; cidx = 8'd55;
								end else begin
									seq_d = S_W_C; carg = item.sector;
									cidx = (item.block_count != 16'd1) ? 8'd25 : 8'd24;
								end
							end
						end
						OP_SYNC: begin seq_d = S_SYNC; rdy = 1'b1; end
						OP_CSD: begin seq_d = S_REG_C; cmd = 1'b1; cidx = 8'd9; ccrc = 8'hFF; end
						OP_CID: begin seq_d = S_REG_C; cmd = 1'b1; cidx = 8'd10; ccrc = 8'hFF; end
						OP_OCR: begin
							seq_d = S_OCR_C1; cmd = 1'b1; cidx = 8'd58;
							carg = 32'h40000000; ccrc = 8'h6F;
						end
						default: begin fin = 1'b1; fst = ST_ERR; end
					endcase
				end
				RT_BYTE: begin
					case (phase_q)
						PH_FILL: begin
							if (bidx_q == 10'd0) do_cont = 1'b1;
							else begin bidx_d = bidx_q - 10'd1; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF; end
						end
						PH_CFLUSH: begin
							cs_d = 1'b1; phase_d = PH_CPRE; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
						end
						PH_CPRE: begin
							phase_d = PH_CFRAME; bidx_d = 10'd0;
							o_v = 1'b1; o_txv = 1'b1; o_txb = frame_q[47:40];
						end
						PH_CFRAME: begin
							o_v = 1'b1; o_txv = 1'b1;
							if (bidx_q < 10'd5) begin
								bidx_d = bidx_q + 10'd1;
								case (bidx_q[2:0])
									3'd0: o_txb = frame_q[39:32];
									3'd1: o_txb = frame_q[31:24];
									3'd2: o_txb = frame_q[23:16];
									3'd3: o_txb = frame_q[15:8];
									default: o_txb = frame_q[7:0];
								endcase
							end else begin
								phase_d = PH_CPOLL; poll_d = cfg.tries; o_txb = 8'hFF;
							end
						end
						PH_CPOLL: begin
							if (b[7] && poll_q != 8'd0) begin
								poll_d = poll_q - 8'd1; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
							end else begin cs_d = 1'b0; do_cont = 1'b1; cv = b; end
						end
						PH_TOKEN: begin
							if (b == 8'hFF && tick_q < cfg.timeout) begin
								o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
							end else if (b != 8'hFE) begin cs_d = 1'b0; do_cont = 1'b1; end
							else begin
								phase_d = PH_RDATA; bidx_d = 10'd0;
								o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
							end
						end
						PH_RDATA: begin
							if (seq_q == S_I_R7) begin
								if (bidx_q == 10'd2) r7_d = b[0];
								if (bidx_q == 10'd3) r7_d = r7_q && b == 8'hAA;
							end else if (seq_q == S_OCR_R1 || seq_q == S_OCR_R2) begin
								if (bidx_q == 10'd0) ochc_d = b[6];
								if (bidx_q == 10'd2) oret_d = b[6];
							end else if (seq_q == S_REG_R && op_q == OP_INIT) begin
								if (bidx_q == 10'd7) csd_d[21:16] = b[5:0];
								if (bidx_q == 10'd8) csd_d[15:8] = b;
								if (bidx_q == 10'd9) csd_d[7:0] = b;
							end
							if (emit_q) begin o_rv = 1'b1; o_rd = b; end
							if (rlong_q ? (bidx_q != 10'd511) :
								({5'd0, bidx_q[4:0]} + 10'd1 < {5'd0, rlen_q}) || bidx_q[9:5] != 5'd0 && 1'b0)
								bidx_d = bidx_q + 10'd1;
							else begin phase_d = PH_RCRC; bidx_d = 10'd0; end
							o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
						end
						PH_RCRC: begin
							if (bidx_q == 10'd0) begin
								bidx_d = 10'd1; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
							end else begin cs_d = 1'b0; do_cont = 1'b1; cv = 8'd1; end
						end
						PH_READY: begin
							if (b == 8'hFF) begin do_cont = 1'b1; cv = 8'd1; end
							else if (tick_q > cfg.timeout) do_cont = 1'b1;
							else begin o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF; end
						end
						PH_WTOKEN: begin
							phase_d = PH_WAITWB; bidx_d = 10'd0; o_v = 1'b1; o_nwb = 1'b1;
						end
						PH_WDATA: begin
							o_v = 1'b1;
							if (bidx_q != 10'(BLOCK_BYTES - 1)) begin
								bidx_d = bidx_q + 10'd1; phase_d = PH_WAITWB; o_nwb = 1'b1;
							end else begin
								phase_d = PH_WCRC; bidx_d = 10'd0; o_txv = 1'b1; o_txb = 8'hFF;
							end
						end
						PH_WCRC: begin
							o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
							if (bidx_q == 10'd0) bidx_d = 10'd1;
							else phase_d = PH_WRESP;
						end
						PH_WRESP: begin
							if (b[4:0] != 5'h05) begin fin = 1'b1; fst = ST_ERR; end
							else begin
								blk_d = blk_m;
								if (blk_m != 16'd0) begin seq_d = S_W_RDY; rdy = 1'b1; end
								else if (multi_q) begin seq_d = S_W_END; rdy = 1'b1; end
								else fin = 1'b1;
							end
						end
						PH_STOP: fin = 1'b1;
						default: ;
					endcase
				end
				RT_TICK: if (tick_q != 16'hFFFF) tick_d = tick_q + 16'd1;
				default: if (phase_q == PH_WAITWB) begin
					phase_d = PH_WDATA; o_v = 1'b1; o_txv = 1'b1; o_txb = item.write_byte;
				end
			endcase
		end
		if (do_cont) begin
			case (seq_q)
				S_I_FLUSH: begin seq_d = S_I_CMD0; cmd = 1'b1; ccrc = 8'h95; end
				S_I_CMD0: begin
					if (cv != 8'd1) begin fin = 1'b1; fst = ST_NRDY; end
					else begin seq_d = S_I_CMD8; cmd = 1'b1; cidx = 8'd8; carg = 32'h1AA; ccrc = 8'h87; end
				end
				S_I_CMD8: begin
					if (cv == 8'd1) begin seq_d = S_I_R7; r7_d = 1'b0; resp = 1'b1; rl = 16'd4; end
					else begin tick_d = 16'd0; seq_d = S_I_C55; cmd = 1'b1; cidx = 8'd55; ccrc = 8'h65; end
				end
				S_I_R7: begin
					if (!r7_q) begin fin = 1'b1; fst = ST_NRDY; end
					else begin
						kind_d = 2'd2; hcs_d = 1'b1; tick_d = 16'd0; seq_d = S_I_C55;
						cmd = 1'b1; cidx = 8'd55; ccrc = 8'h65;
					end
				end
				S_I_C55, S_I_C41: begin
					if ((seq_q == S_I_C55) ? (cv > 8'd1) : (cv != 8'd0)) begin
						cmd = 1'b1;
						if (tick_q > cfg.timeout) begin
							kind_d = 2'd3; tick_d = 16'd0; seq_d = S_I_C1; cidx = 8'd1; ccrc = 8'hF9;
						end else begin seq_d = S_I_C55; cidx = 8'd55; ccrc = 8'h65; end
					end else if (seq_q == S_I_C55) begin
						seq_d = S_I_C41; cmd = 1'b1; cidx = 8'd41;
						carg = hcs_q ? 32'h40000000 : 32'd0; ccrc = hcs_q ? 8'h77 : 8'hE5;
					end else begin
						if (kind_q == 2'd0) kind_d = 2'd1;
						seq_d = S_OCR_C1; cmd = 1'b1; cidx = 8'd58; carg = 32'h40000000; ccrc = 8'h6F;
					end
				end
				S_I_C1: begin
					if (cv == 8'd0) begin
						if (kind_q == 2'd0) kind_d = 2'd1;
						seq_d = S_OCR_C1; cmd = 1'b1; cidx = 8'd58; carg = 32'h40000000; ccrc = 8'h6F;
					end else if (tick_q > cfg.timeout) begin fin = 1'b1; fst = ST_NRDY; end
					else begin cmd = 1'b1; cidx = 8'd1; ccrc = 8'hF9; end
				end
				S_OCR_C1, S_OCR_C2: begin
					seq_d = (seq_q == S_OCR_C1) ? S_OCR_R1 : S_OCR_R2;
					if (seq_q == S_OCR_C1) oret_d = 1'b0;
					resp = 1'b1; rl = 16'd4; remit = op_q == OP_OCR;
				end
				S_OCR_R1, S_OCR_R2: begin
					if (seq_q == S_OCR_R1 && oret_q) begin
						seq_d = S_OCR_C2; cmd = 1'b1; cidx = 8'd58; ccrc = 8'hFD;
					end else if (op_q == OP_INIT) begin
						dens_d = ochc_q; seq_d = S_I_C59; cmd = 1'b1; cidx = 8'd59; ccrc = 8'h91;
					end else fin = 1'b1;
				end
				S_I_C59: begin
					seq_d = S_I_C16; cmd = 1'b1; cidx = 8'd16; carg = 32'(BLOCK_BYTES); ccrc = 8'h15;
				end
				S_I_C16: begin csd_d = 22'd0; seq_d = S_REG_C; cmd = 1'b1; cidx = 8'd9; ccrc = 8'hFF; end
				S_REG_C, S_REG_R: begin
					if (seq_q == S_REG_C && cv == 8'd0) begin
						seq_d = S_REG_R; resp = 1'b1; rl = 16'd16; rwait = 1'b1;
						remit = op_q != OP_INIT;
					end else begin
						ok = (seq_q == S_REG_R) && cv != 8'd0;
						fin = 1'b1;
						if (op_q == OP_INIT) begin
							cp1 = ok ? ({1'b0, csd_q} + 23'd1) : 23'd1;
							total_d = cp1[22] ? 32'hFFFFFFFF : {cp1[21:0], 10'd0};
							if (!ok) csd_d = 22'd0;
							rdy_d = 1'b1;
						end else fst = ok ? ST_OK : ST_ERR;
					end
				end
				S_R_C: begin
					if (cv != 8'd0) begin fin = 1'b1; fst = ST_ERR; end
					else begin seq_d = S_R_D; resp = 1'b1; rl = 16'(BLOCK_BYTES); rwait = 1'b1; remit = 1'b1; end
				end
				S_R_D: begin
					if (cv == 8'd0) begin fin = 1'b1; fst = ST_ERR; end
					else if (!multi_q) fin = 1'b1;
					else begin
						blk_d = blk_m;
						if (blk_m != 16'd0) begin
							resp = 1'b1; rl = 16'(BLOCK_BYTES); rwait = 1'b1; remit = 1'b1;
						end else begin seq_d = S_R_STOP; cmd = 1'b1; cidx = 8'd12; ccrc = 8'hFF; end
					end
				end
				S_R_STOP: begin seq_d = S_R_FILL; fill = 1'b1; flen = 16'd10; end
				S_R_FILL: fin = 1'b1;
				S_W_55: begin seq_d = S_W_23; cmd = 1'b1; cidx = 8'd23; carg = {16'd0, blk_q}; ccrc = 8'hFF; end
				S_W_23: begin seq_d = S_W_C; cmd = 1'b1; cidx = 8'd25; carg = sec_q; ccrc = 8'hFF; end
				S_W_C: begin
					if (cv != 8'd0) begin fin = 1'b1; fst = ST_ERR; end
					else begin cs_d = 1'b1; seq_d = S_W_RDY; rdy = 1'b1; end
				end
				S_W_RDY: begin
					if (cv == 8'd0) begin fin = 1'b1; fst = ST_ERR; end
					else begin phase_d = PH_WTOKEN; o_v = 1'b1; o_txv = 1'b1; o_txb = multi_q ? 8'hFC : 8'hFE; end
				end
				S_W_END: begin
					if (cv == 8'd0) begin fin = 1'b1; fst = ST_ERR; end
					else begin phase_d = PH_STOP; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFD; end
				end
				S_SYNC: begin fin = 1'b1; fst = (cv != 8'd0) ? ST_OK : ST_ERR; end
				default: begin fin = 1'b1; fst = ST_ERR; end
			endcase
		end
		if (fill) begin
			phase_d = PH_FILL; bidx_d = flen[9:0] - 10'd1; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
		end
		if (cmd) begin
			frame_d = {8'h40 | cidx, carg, ccrc}; cs_d = 1'b0; phase_d = PH_CFLUSH;
			o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
		end
		if (resp) begin
			cs_d = 1'b1; rlong_d = rl[9]; rlen_d = rl[4:0]; emit_d = remit; bidx_d = 10'd0;
			if (rwait) begin tick_d = 16'd0; phase_d = PH_TOKEN; end
			else phase_d = PH_RDATA;
			o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF;
		end
		if (rdy) begin tick_d = 16'd0; phase_d = PH_READY; o_v = 1'b1; o_txv = 1'b1; o_txb = 8'hFF; end
		if (fin) begin
			phase_d = PH_IDLE; seq_d = S_NONE; cs_d = 1'b0; o_v = 1'b1; o_dn = 1'b1; o_st = fst;
		end
		res_emit = o_v;
		res.tx_valid = o_txv; res.tx_byte = o_txb; res.cs_low = cs_d;
		res.read_valid = o_rv; res.read_data = o_rd; res.need_write_byte = o_nwb;
		res.done_res = o_dn; res.status = o_st; res.card_kind = kind_d;
		res.high_capacity = dens_d; res.sector_total = total_d; res.card_ready = rdy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; seq_q <= S_NONE; bidx_q <= '0; blk_q <= '0; tick_q <= '0;
			poll_q <= '0; frame_q <= '0; csd_q <= '0; kind_q <= '0; dens_q <= 1'b0;
			rdy_q <= 1'b0; total_q <= '0; sec_q <= '0; op_q <= OP_INIT; cs_q <= 1'b0;
			emit_q <= 1'b0; multi_q <= 1'b0; hcs_q <= 1'b0; r7_q <= 1'b0; ochc_q <= 1'b0;
			oret_q <= 1'b0; rlen_q <= '0; rlong_q <= 1'b0;
		end else begin
			phase_q <= phase_d; seq_q <= seq_d; bidx_q <= bidx_d; blk_q <= blk_d; tick_q <= tick_d;
			poll_q <= poll_d; frame_q <= frame_d; csd_q <= csd_d; kind_q <= kind_d; dens_q <= dens_d;
			rdy_q <= rdy_d; total_q <= total_d; sec_q <= sec_d; op_q <= op_d; cs_q <= cs_d;
			emit_q <= emit_d; multi_q <= multi_d; hcs_q <= hcs_d; r7_q <= r7_d; ochc_q <= ochc_d;
			oret_q <= oret_d; rlen_q <= rlen_d; rlong_q <= rlong_d;
		end
	end
endmodule

// ===== hdl/sdsh_checker.sv =====
// Port-level checker for the SD SPI host sequencer, bound to the top level.
// Depends on the top level's ports only.
module sdsh_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [63:0] m_axis_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");
	a_txz: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'd0)
		else $error("tx_byte set without tx_valid");
	a_done_cs: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[20] |-> !m_axis_tdata[9])
		else $error("chip select held at completion");
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output drains");
endmodule

bind sd_spi_host_sequencer sdsh_checker u_chk (.clk, .arst_n, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tdata);

// ===== dv/tb_top.sv =====
// Testbench for sd_spi_host_sequencer: emulates the card behind the SPI link, drives
// event streams with random gaps and stalls, and checks every result against a predictor.
// Depends on sdsh_pkg and the block's RTL.
module tb_top;
	import sdsh_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	class card_scoreboard;
		bit [7:0] tries = 10;
		bit [15:0] tmo = 255;
		bit wprot;
		logic [5:0] ph = PH_IDLE;
		logic [4:0] seq = S_NONE;
		bit [15:0] idx, blk, ticks, rlen;
		bit [7:0] polls;
		bit [47:0] frame;
		bit [23:0] csd;
		bit [1:0] kind;
		bit dens, rdy;
		bit [31:0] total, arg;
		bit [2:0] cur;
		bit cs, emit, multi, hcs, r7ok, ohc, oretry, prv;
		bit [7:0] prd;
		res_t pending[$];
		int errs, shown;

		function void put(bit txv, bit [7:0] txb, bit nwb, bit dn, bit [1:0] st);
			res_t r;
			r.tx_valid = txv;
			r.tx_byte = txv ? txb : 8'h00;
			r.cs_low = cs;
			r.read_valid = prv;
			r.read_data = prv ? prd : 8'h00;
			r.need_write_byte = nwb;
			r.done_res = dn;
			r.status = dn ? st : ST_OK;
			r.card_kind = kind;
			r.high_capacity = dens;
			r.sector_total = total;
			r.card_ready = rdy;
			pending.push_back(r);
			prv = 0;
		endfunction

		function void tx(bit [7:0] b);
			put(1, b, 0, 0, ST_OK);
		endfunction

		function void finish(bit [1:0] st);
			ph = PH_IDLE;
			seq = S_NONE;
			cs = 0;
			put(0, 0, 0, 1, st);
		endfunction

		function void fill(bit [15:0] n);
			ph = PH_FILL;
			idx = n - 16'd1;
			tx(8'hFF);
		endfunction

		function void cmd(bit [7:0] c, bit [31:0] a, bit [7:0] crc);
			frame = {8'h40 | c, a, crc};
			cs = 0;
			ph = PH_CFLUSH;
			tx(8'hFF);
		endfunction

		function void resp(bit [15:0] len, bit wait_tok, bit em);
			cs = 1;
			rlen = len;
			emit = em;
			idx = 0;
			if (wait_tok) begin
				ticks = 0;
				ph = PH_TOKEN;
			end else
				ph = PH_RDATA;
			tx(8'hFF);
		endfunction

		function void ready_poll();
			ticks = 0;
			ph = PH_READY;
			tx(8'hFF);
		endfunction

		function void capture(bit [15:0] i, bit [7:0] b);
			if (seq == S_I_R7) begin
				if (i == 2) r7ok = b[0];
				if (i == 3) r7ok = r7ok && b == 8'hAA;
			end else if (seq == S_OCR_R1 || seq == S_OCR_R2) begin
				if (i == 0) ohc = b[6];
				if (i == 2) oretry = b[6];
			end else if (seq == S_REG_R && cur == OP_INIT) begin
				if (i == 7) csd[23:16] = {2'b00, b[5:0]};
				if (i == 8) csd[15:8] = b;
				if (i == 9) csd[7:0] = b;
			end
		endfunction

		function void init_retry();
			if (ticks > tmo) begin
				kind = 3;
				ticks = 0;
				seq = S_I_C1;
				cmd(1, 0, 8'hF9);
			end else begin
				seq = S_I_C55;
				cmd(55, 0, 8'h65);
			end
		endfunction

		function void after_acmd();
			if (kind == 0) kind = 1;
			seq = S_OCR_C1;
			cmd(58, 32'h40000000, 8'h6F);
		endfunction

		function void ocr_end();
			if (cur == OP_INIT) begin
				dens = ohc;
				seq = S_I_C59;
				cmd(59, 0, 8'h91);
			end else
				finish(ST_OK);
		endfunction

		function void reg_end(bit ok);
			bit [63:0] n;
			if (cur == OP_INIT) begin
				if (!ok) csd = 0;
				n = (64'(csd[21:0]) + 1) << 10;
				total = n > 64'hFFFFFFFF ? 32'hFFFFFFFF : n[31:0];
				rdy = 1;
				finish(ST_OK);
			end else
				finish(ok ? ST_OK : ST_ERR);
		endfunction

		function void advance(bit [7:0] v);
			case (seq)
			S_I_FLUSH: begin seq = S_I_CMD0; cmd(0, 0, 8'h95); end
			S_I_CMD0: begin
				if (v != 1) finish(ST_NRDY);
				else begin seq = S_I_CMD8; cmd(8, 32'h1AA, 8'h87); end
			end
			S_I_CMD8: begin
				if (v == 1) begin seq = S_I_R7; r7ok = 0; resp(4, 0, 0); end
				else begin ticks = 0; seq = S_I_C55; cmd(55, 0, 8'h65); end
			end
			S_I_R7: begin
				if (!r7ok) finish(ST_NRDY);
				else begin
					kind = 2;
					hcs = 1;
					ticks = 0;
					seq = S_I_C55;
					cmd(55, 0, 8'h65);
				end
			end
			S_I_C55: begin
				if (v > 1) init_retry();
				else begin
					seq = S_I_C41;
					cmd(41, hcs ? 32'h40000000 : 32'h0, hcs ? 8'h77 : 8'hE5);
				end
			end
			S_I_C41: if (v != 0) init_retry(); else after_acmd();
			S_I_C1: begin
				if (v == 0) after_acmd();
				else if (ticks > tmo) finish(ST_NRDY);
				else cmd(1, 0, 8'hF9);
			end
			S_OCR_C1: begin seq = S_OCR_R1; oretry = 0; resp(4, 0, cur == OP_OCR); end
			S_OCR_R1: begin
				if (oretry) begin seq = S_OCR_C2; cmd(58, 0, 8'hFD); end
				else ocr_end();
			end
			S_OCR_C2: begin seq = S_OCR_R2; resp(4, 0, cur == OP_OCR); end
			S_OCR_R2: ocr_end();
			S_I_C59: begin seq = S_I_C16; cmd(16, BLOCK_BYTES, 8'h15); end
			S_I_C16: begin csd = 0; seq = S_REG_C; cmd(9, 0, 8'hFF); end
			S_REG_C: begin
				if (v != 0) reg_end(0);
				else begin seq = S_REG_R; resp(16, 1, cur != OP_INIT); end
			end
			S_REG_R: reg_end(v != 0);
			S_R_C: begin
				if (v != 0) finish(ST_ERR);
				else begin seq = S_R_D; resp(16'(BLOCK_BYTES), 1, 1); end
			end
			S_R_D: begin
				if (v == 0) finish(ST_ERR);
				else if (!multi) finish(ST_OK);
				else begin
					blk--;
					if (blk != 0) resp(16'(BLOCK_BYTES), 1, 1);
					else begin seq = S_R_STOP; cmd(12, 0, 8'hFF); end
				end
			end
			S_R_STOP: begin seq = S_R_FILL; fill(10); end
			S_R_FILL: finish(ST_OK);
			S_W_55: begin seq = S_W_23; cmd(23, 32'(blk), 8'hFF); end
			S_W_23: begin seq = S_W_C; cmd(25, arg, 8'hFF); end
			S_W_C: begin
				if (v != 0) finish(ST_ERR);
				else begin cs = 1; seq = S_W_RDY; ready_poll(); end
			end
			S_W_RDY: begin
				if (v == 0) finish(ST_ERR);
				else begin ph = PH_WTOKEN; tx(multi ? 8'hFC : 8'hFE); end
			end
			S_W_END: begin
				if (v == 0) finish(ST_ERR);
				else begin ph = PH_STOP; tx(8'hFD); end
			end
			S_SYNC: finish(v ? ST_OK : ST_ERR);
			default: finish(ST_ERR);
			endcase
		endfunction

		function void start_op(bit [2:0] op, bit [31:0] sec, bit [15:0] cnt);
			cur = op;
			case (op)
			OP_INIT: begin
				kind = 0; dens = 0; rdy = 0; total = 0; hcs = 0; cs = 0;
				seq = S_I_FLUSH;
				fill(15);
			end
			OP_READ: begin
				if (!rdy) finish(ST_NRDY);
				else begin
					blk = cnt; multi = cnt != 1; arg = sec;
					seq = S_R_C;
					cmd(multi ? 8'd18 : 8'd17, sec, 8'hFF);
				end
			end
			OP_WRITE: begin
				if (!rdy) finish(ST_NRDY);
				else if (wprot) finish(ST_WP);
				else begin
					blk = cnt; multi = cnt != 1; arg = sec;
					if (multi && kind == 3) begin seq = S_W_55; cmd(55, 0, 8'hFF); end
					else begin seq = S_W_C; cmd(multi ? 8'd25 : 8'd24, sec, 8'hFF); end
				end
			end
			OP_SYNC: begin seq = S_SYNC; ready_poll(); end
			OP_CSD: begin seq = S_REG_C; cmd(9, 0, 8'hFF); end
			OP_CID: begin seq = S_REG_C; cmd(10, 0, 8'hFF); end
			OP_OCR: begin seq = S_OCR_C1; cmd(58, 32'h40000000, 8'h6F); end
			default: finish(ST_ERR);
			endcase
		endfunction

		function void on_byte(bit [7:0] b);
			case (ph)
			PH_FILL: begin
				if (idx == 0) advance(0);
				else begin idx--; tx(8'hFF); end
			end
			PH_CFLUSH: begin cs = 1; ph = PH_CPRE; tx(8'hFF); end
			PH_CPRE: begin ph = PH_CFRAME; idx = 0; tx(frame[47:40]); end
			PH_CFRAME: begin
				if (idx < 5) begin
					idx++;
					tx(8'(frame >> (40 - 8 * idx)));
				end else begin
					ph = PH_CPOLL;
					polls = tries;
					tx(8'hFF);
				end
			end
			PH_CPOLL: begin
				if (b[7] && polls != 0) begin polls--; tx(8'hFF); end
				else begin cs = 0; advance(b); end
			end
			PH_TOKEN: begin
				if (b == 8'hFF && ticks < tmo) tx(8'hFF);
				else if (b != 8'hFE) begin cs = 0; advance(0); end
				else begin ph = PH_RDATA; idx = 0; tx(8'hFF); end
			end
			PH_RDATA: begin
				capture(idx, b);
				if (emit) begin prv = 1; prd = b; end
				if (32'(idx) + 1 < 32'(rlen)) idx++;
				else begin ph = PH_RCRC; idx = 0; end
				tx(8'hFF);
			end
			PH_RCRC: begin
				if (idx == 0) begin idx = 1; tx(8'hFF); end
				else begin cs = 0; advance(1); end
			end
			PH_READY: begin
				if (b == 8'hFF) advance(1);
				else if (ticks > tmo) advance(0);
				else tx(8'hFF);
			end
			PH_WTOKEN: begin ph = PH_WAITWB; idx = 0; put(0, 0, 1, 0, ST_OK); end
			PH_WDATA: begin
				if (32'(idx) + 1 < BLOCK_BYTES) begin
					idx++;
					ph = PH_WAITWB;
					put(0, 0, 1, 0, ST_OK);
				end else begin
					ph = PH_WCRC; idx = 0; tx(8'hFF);
				end
			end
			PH_WCRC: begin
				if (idx == 0) begin idx = 1; tx(8'hFF); end
				else begin ph = PH_WRESP; tx(8'hFF); end
			end
			PH_WRESP: begin
				if (b[4:0] != 5'h05) finish(ST_ERR);
				else begin
					blk--;
					if (blk != 0) begin seq = S_W_RDY; ready_poll(); end
					else if (multi) begin seq = S_W_END; ready_poll(); end
					else finish(ST_OK);
				end
			end
			PH_STOP: finish(ST_OK);
			default: ;
			endcase
		endfunction

		function void note_event(bit [1:0] rt, item_t it);
			prv = 0;
			case (rt)
			RT_START: if (ph == PH_IDLE) start_op(it.op, it.sector, it.block_count);
			RT_BYTE: on_byte(it.miso_byte);
			RT_TICK: if (ticks != 16'hFFFF) ticks++;
			default: if (ph == PH_WAITWB) begin ph = PH_WDATA; tx(it.write_byte); end
			endcase
		endfunction

		function void check_result(res_t got);
			res_t exp;
			if (pending.size() == 0) begin
				errs++;
				if (shown < 10) begin
					shown++;
					$display("unexpected result %h", got);
				end
				return;
			end
			exp = pending.pop_front();
			if (got.tx_valid !== exp.tx_valid || got.tx_byte !== exp.tx_byte ||
					got.cs_low !== exp.cs_low || got.read_valid !== exp.read_valid ||
					got.read_data !== exp.read_data ||
					got.need_write_byte !== exp.need_write_byte ||
					got.done_res !== exp.done_res || got.status !== exp.status ||
					got.card_kind !== exp.card_kind || got.high_capacity !== exp.high_capacity ||
					got.sector_total !== exp.sector_total || got.card_ready !== exp.card_ready) begin
				errs++;
				if (shown < 10) begin
					shown++;
					$display("mismatch: txv %b/%b tx %h/%h cs %b/%b rv %b/%b rd %h/%h nwb %b/%b",
						exp.tx_valid, got.tx_valid, exp.tx_byte, got.tx_byte, exp.cs_low,
						got.cs_low, exp.read_valid, got.read_valid, exp.read_data,
						got.read_data, exp.need_write_byte, got.need_write_byte);
					$display("  done %b/%b st %h/%h kind %h/%h hc %b/%b total %h/%h rdy %b/%b",
						exp.done_res, got.done_res, exp.status, got.status, exp.card_kind,
						got.card_kind, exp.high_capacity, got.high_capacity,
						exp.sector_total, got.sector_total, exp.card_ready, got.card_ready);
				end
			end
		endfunction
	endclass

	localparam int IDLE_LIMIT = 5000;

	logic clk, arst_n;
	logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
	logic [71:0] s_axis_tdata;
	logic [1:0] s_axis_tuser;
	logic [63:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	card_scoreboard sb = new();
	int quiet, burst_left, events_sent, stall_mode;
	bit bad_token;

	sd_spi_host_sequencer DUT (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			res_t r;
			r = m_axis_tdata[58:0];
			r = '{tx_valid: m_axis_tdata[0], tx_byte: m_axis_tdata[8:1],
				cs_low: m_axis_tdata[9], read_valid: m_axis_tdata[10],
				read_data: m_axis_tdata[18:11], need_write_byte: m_axis_tdata[19],
				done_res: m_axis_tdata[20], status: m_axis_tdata[22:21],
				card_kind: m_axis_tdata[24:23], high_capacity: m_axis_tdata[25],
				sector_total: m_axis_tdata[57:26], card_ready: m_axis_tdata[58]};
			sb.check_result(r);
		end
		if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > IDLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: alternate free-running stretches with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_mode <= 0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode <= $urandom_range(0, 2);
			case (stall_mode)
			0: m_axis_tready <= 1'b1;
			1: m_axis_tready <= $urandom_range(0, 3) != 0;
			default: m_axis_tready <= $urandom_range(0, 4) == 0;
			endcase
		end
	end

	task automatic send(bit [1:0] rt, item_t it);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= rt;
		s_axis_tdata <= {5'b0, it.write_byte, it.miso_byte, it.block_count, it.sector, it.op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_event(rt, it);
		events_sent++;
	endtask

	task automatic write_reg(bit [1:0] idx, bit [15:0] val);
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		CFG_TRIES: sb.tries = val[7:0];
		CFG_TIMEOUT: sb.tmo = val;
		default: sb.wprot = val[0];
		endcase
	endtask

	function automatic bit [7:0] card_reply();
		if (sb.ph == PH_CPOLL) begin
			if ($urandom_range(0, 9) == 0) return 8'($urandom);
			if ($urandom_range(0, 7) == 0) return 8'hFF;
			case (sb.seq)
			S_I_CMD0: return 8'h01;
			S_I_CMD8: return $urandom_range(0, 3) == 0 ? 8'h05 : 8'h01;
			S_I_C55: return 8'h01;
			S_I_C41, S_I_C1: return $urandom_range(0, 4) == 0 ? 8'h01 : 8'h00;
			S_W_C: return bad_token ? 8'h01 : 8'h00;
			default: return 8'h00;
			endcase
		end
		if (sb.ph == PH_TOKEN) begin
			if (bad_token) return 8'h00;
			case ($urandom_range(0, 19))
			0, 1: return 8'hFF;
			2: return 8'($urandom);
			default: return 8'hFE;
			endcase
		end
		if (sb.ph == PH_RDATA && sb.seq == S_I_R7 && sb.idx >= 2 && $urandom_range(0, 9) != 0)
			return sb.idx == 2 ? 8'h01 : 8'hAA;
		if (sb.ph == PH_WRESP)
			return $urandom_range(0, 9) == 0 ? 8'($urandom) : 8'(($urandom & 8'hE0) | 8'h05);
		if (sb.ph == PH_READY)
			return $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic run_op(bit [2:0] op, bit [15:0] cnt, bit abort);
		item_t it;
		it = '0;
		it.op = op;
		it.sector = $urandom;
		it.block_count = cnt;
		bad_token = abort;
		send(RT_START, it);
		while (sb.ph != PH_IDLE) begin
			it = '0;
			it.op = 3'($urandom);
			it.sector = $urandom;
			it.block_count = 16'($urandom);
			it.miso_byte = card_reply();
			it.write_byte = 8'($urandom);
			case ($urandom_range(0, 39))
			0, 1: send(RT_TICK, it);
			2: send(RT_START, it);
			3: send(sb.ph == PH_WAITWB ? RT_BYTE : RT_WBYTE, it);
			default: send(sb.ph == PH_WAITWB ? RT_WBYTE : RT_BYTE, it);
			endcase
		end
		bad_token = 0;
	endtask

	task automatic random_ops(int budget);
		int stop_at;
		bit [2:0] op;
		bit [15:0] cnt;
		bit abort;
		item_t it;
		stop_at = events_sent + budget;
		while (events_sent < stop_at) begin
			if ($urandom_range(0, 5) == 0) begin
				it = '0;
				it.miso_byte = 8'($urandom);
				it.write_byte = 8'($urandom);
				send(2'($urandom_range(1, 3)), it);
			end
			op = sb.rdy ? 3'($urandom_range(0, 7)) : ($urandom_range(0, 3) == 0 ?
				3'($urandom_range(1, 7)) : OP_INIT);
			cnt = $urandom_range(0, 3) == 0 ? 16'($urandom_range(2, 3)) : 16'd1;
			if ((op == OP_READ || op == OP_WRITE) && $urandom_range(0, 9) == 0)
				cnt = 16'($urandom);
			if (op == OP_READ && $urandom_range(0, 2) != 0)
				op = OP_SYNC;
			abort = op == OP_READ || op == OP_WRITE;
			run_op(op, cnt, abort);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = RT_START;
		cfg_we = 1'b0;
		cfg_index = CFG_TRIES;
		cfg_data = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_op(OP_READ, 1, 0);
		run_op(OP_WRITE, 1, 0);
		run_op(3'd7, 1, 0);
		run_op(OP_SYNC, 1, 0);
		while (!sb.rdy) run_op(OP_INIT, 1, 0);
		run_op(OP_CSD, 1, 0);
		run_op(OP_CID, 1, 0);
		run_op(OP_OCR, 1, 0);
		run_op(OP_READ, 16'h0000, 1);
		run_op(OP_READ, 16'hFFFF, 1);
		run_op(OP_WRITE, 16'h0000, 1);
		run_op(OP_WRITE, 16'h8000, 1);
		run_op(OP_READ, 1, 1);
		run_op(OP_WRITE, 1, 1);
		run_op(OP_WRITE, 2, 1);
		run_op(3'd7, 1, 0);
		random_ops(30);

		write_reg(CFG_TRIES, 16'd0);
		write_reg(CFG_TIMEOUT, 16'd1);
		write_reg(CFG_WP, 16'd1);
		run_op(OP_WRITE, 1, 0);
		random_ops(30);

		write_reg(CFG_TRIES, 16'd255);
		write_reg(CFG_TIMEOUT, 16'hFFFF);
		write_reg(CFG_WP, 16'd0);
		random_ops(30);

		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errs == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
